@@ src/stvc_pkg.sv @@
// Package with shared types, constants and helpers for the sparse contraction block.
package stvc_pkg;

    localparam int VectorDepth = 1024;
    localparam int AddrBits = 10;
    localparam int KeyBits = 48;
    localparam int ValueBits = 24;
    localparam int AccBits = 48;
    localparam int HalfBits = AccBits / 2;
    localparam int ThrBits = 47;
    localparam int ProdBits = 2 * ValueBits;
    localparam int TermBits = ProdBits + 1;
    localparam int SqBits = 2 * AccBits;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_ENTRY = 1'b1;

    typedef struct packed {
        logic                        mode;
        logic [AddrBits-1:0]         vec_addr;
        logic signed [ValueBits-1:0] vec_re;
        logic signed [ValueBits-1:0] vec_im;
        logic [KeyBits-1:0]          prefix_key;
        logic [AddrBits-1:0]         last_coord;
        logic signed [ValueBits-1:0] entry_re;
        logic signed [ValueBits-1:0] entry_im;
        logic                        end_of_stream;
    } in_item_t;

    typedef struct packed {
        logic [KeyBits-1:0]        out_key;
        logic signed [AccBits-1:0] sum_re;
        logic signed [AccBits-1:0] sum_im;
        logic                      last_in_step;
    } out_item_t;

    // Work handed from the front part to the back part.
    typedef struct packed {
        logic [KeyBits-1:0]          key;
        logic [AddrBits-1:0]         coord;
        logic signed [ValueBits-1:0] er;
        logic signed [ValueBits-1:0] ei;
        logic                        close_old;
        logic                        eos;
    } cmd_t;

    localparam int QueueDepth = 2;
    localparam int QueueBits = 1;

    function automatic logic [AccBits-1:0] mag(input logic signed [AccBits-1:0] v);
        logic [AccBits-1:0] r;
        r = v[AccBits-1] ? AccBits'(-v) : AccBits'(v);
        return r;
    endfunction

endpackage

@@ src/stvc_front.sv @@
// Front part: gates loads of the vector store, tracks the open group and queues entry commands.
module stvc_front import stvc_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  in_item_t s_data,
    output logic     cmd_valid,
    input  logic     cmd_ready,
    output cmd_t     cmd_data
);

    logic [KeyBits-1:0] open_key_reg, open_key_next;
    logic               open_reg, open_next;
    cmd_t               q_mem [QueueDepth];
    logic [QueueBits-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QueueBits:0]   cnt_reg;
    logic               push, pop, is_entry;
    cmd_t               cmd;

    // A load waits until every queued entry has read the vector store.
    assign is_entry = (s_data.mode == MODE_ENTRY);
    assign s_ready  = is_entry ? (cnt_reg != (QueueBits+1)'(QueueDepth)) : (cnt_reg == '0);
    assign push     = s_valid && s_ready && is_entry;
    assign pop      = cmd_valid && cmd_ready;
    assign cmd_valid = (cnt_reg != '0);
    assign cmd_data  = q_mem[rd_ptr_reg];

    always_comb begin
        cmd.key       = s_data.prefix_key;
        cmd.coord     = s_data.last_coord;
        cmd.er        = s_data.entry_re;
        cmd.ei        = s_data.entry_im;
        cmd.close_old = open_reg && (s_data.prefix_key != open_key_reg);
        cmd.eos       = s_data.end_of_stream;
        open_key_next = open_key_reg;
        open_next     = open_reg;
        if (push) begin
            open_key_next = s_data.prefix_key;
            open_next     = !s_data.end_of_stream;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            open_key_reg <= '0;
            open_reg     <= 1'b0;
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            cnt_reg      <= '0;
        end else begin
            open_key_reg <= open_key_next;
            open_reg     <= open_next;
            if (push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop) rd_ptr_reg <= rd_ptr_reg + 1'b1;
            cnt_reg <= cnt_reg + (QueueBits+1)'(push) - (QueueBits+1)'(pop);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) q_mem[wr_ptr_reg] <= cmd;
    end

endmodule

@@ src/stvc_back.sv @@
// Back part: vector store, complex multiply-accumulate, threshold test and result register.
module stvc_back import stvc_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               ld_en,
    input  logic [AddrBits-1:0] ld_addr,
    input  logic signed [ValueBits-1:0] ld_re,
    input  logic signed [ValueBits-1:0] ld_im,
    input  logic [ThrBits-1:0] thr,
    input  logic               cmd_valid,
    output logic               cmd_ready,
    input  cmd_t               cmd_data,
    output logic               m_valid,
    input  logic               m_ready,
    output out_item_t          m_data
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_ACC  = 3'd2;
    localparam logic [2:0] ST_SQ   = 3'd3;
    localparam logic [2:0] ST_CMP  = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;
    localparam logic [2:0] ST_SQ2  = 3'd6;

    logic signed [ValueBits-1:0] mem_re [VectorDepth];
    logic signed [ValueBits-1:0] mem_im [VectorDepth];
    logic signed [ValueBits-1:0] vr_reg, vi_reg;

    logic [2:0]  st_reg;
    cmd_t        c_reg;
    logic        phase_reg;  // 0: closing old group, 1: closing new group
    logic signed [ProdBits-1:0] p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg;
    logic signed [AccBits-1:0]  acc_re_reg, acc_im_reg;
    logic signed [AccBits-1:0]  hold_re_reg, hold_im_reg;
    logic [KeyBits-1:0]         hold_key_reg, old_key_reg;
    logic [AccBits-1:0]         re_hh_reg, re_hl_reg, re_ll_reg;
    logic [AccBits-1:0]         im_hh_reg, im_hl_reg, im_ll_reg;
    logic [AccBits-1:0]         t_hh_reg, t_hl_reg, t_ll_reg;
    logic [SqBits-1:0]          sq_re_reg, sq_im_reg, sq_t_reg;
    logic                       pend_valid_reg, keep_reg;
    logic [KeyBits-1:0]         pend_key_reg;
    logic signed [AccBits-1:0]  pend_re_reg, pend_im_reg;
    out_item_t                  out_reg;
    logic                       out_valid_reg;

    logic signed [TermBits-1:0] t_re, t_im;
    logic signed [AccBits+1:0]  s_re, s_im;
    logic signed [AccBits-1:0]  n_re, n_im;
    logic [SqBits:0]            sq_sum;
    logic [AccBits-1:0]         mag_re, mag_im, thr_ext;
    logic                       keep, out_load;

    localparam logic signed [AccBits+1:0] AccMax = (AccBits+2)'({1'b0, {(AccBits-1){1'b1}}});
    localparam logic signed [AccBits+1:0] AccMin = -AccMax - 1;

    assign cmd_ready = (st_reg == ST_IDLE);
    assign m_valid   = out_valid_reg;
    assign m_data    = out_reg;
    assign out_load  = (st_reg == ST_OUT) && (!out_valid_reg || m_ready);

    always_ff @(posedge aclk) begin
        if (ld_en) begin
            mem_re[ld_addr] <= ld_re;
            mem_im[ld_addr] <= ld_im;
        end
        vr_reg <= mem_re[cmd_data.coord];
        vi_reg <= mem_im[cmd_data.coord];
    end

    always_comb begin
        t_re = TermBits'(p_rr_reg) - TermBits'(p_ii_reg);
        t_im = TermBits'(p_ri_reg) + TermBits'(p_ir_reg);
        s_re = (AccBits+2)'(acc_re_reg) + (AccBits+2)'(t_re);
        s_im = (AccBits+2)'(acc_im_reg) + (AccBits+2)'(t_im);
        priority if (s_re > AccMax) n_re = AccMax[AccBits-1:0];
        else if (s_re < AccMin) n_re = AccMin[AccBits-1:0];
        else n_re = s_re[AccBits-1:0];
        priority if (s_im > AccMax) n_im = AccMax[AccBits-1:0];
        else if (s_im < AccMin) n_im = AccMin[AccBits-1:0];
        else n_im = s_im[AccBits-1:0];
        mag_re  = mag(hold_re_reg);
        mag_im  = mag(hold_im_reg);
        thr_ext = AccBits'(thr);
        sq_sum  = (SqBits+1)'(sq_re_reg) + (SqBits+1)'(sq_im_reg);
        keep    = sq_sum > (SqBits+1)'(sq_t_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg         <= ST_IDLE;
            acc_re_reg     <= '0;
            acc_im_reg     <= '0;
            out_valid_reg  <= 1'b0;
            phase_reg      <= 1'b0;
            pend_valid_reg <= 1'b0;
        end else begin
            if (out_load) out_valid_reg <= 1'b1;
            else if (m_ready) out_valid_reg <= 1'b0;
            unique case (st_reg)
                ST_IDLE: begin
                    if (cmd_valid) begin
                        c_reg  <= cmd_data;
                        st_reg <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    p_rr_reg <= c_reg.er * vr_reg;
                    p_ii_reg <= c_reg.ei * vi_reg;
                    p_ri_reg <= c_reg.er * vi_reg;
                    p_ir_reg <= c_reg.ei * vr_reg;
                    if (c_reg.close_old) begin
                        hold_re_reg  <= acc_re_reg;
                        hold_im_reg  <= acc_im_reg;
                        hold_key_reg <= old_key_reg;
                        acc_re_reg   <= '0;
                        acc_im_reg   <= '0;
                        phase_reg    <= 1'b0;
                        st_reg       <= ST_SQ;
                    end else begin
                        st_reg <= ST_ACC;
                    end
                end
                ST_ACC: begin
                    old_key_reg <= c_reg.key;
                    if (c_reg.eos) begin
                        hold_re_reg  <= n_re;
                        hold_im_reg  <= n_im;
                        hold_key_reg <= c_reg.key;
                        acc_re_reg   <= '0;
                        acc_im_reg   <= '0;
                        phase_reg    <= 1'b1;
                        st_reg       <= ST_SQ;
                    end else begin
                        acc_re_reg <= n_re;
                        acc_im_reg <= n_im;
                        st_reg     <= ST_IDLE;
                    end
                end
                ST_SQ: begin
                    re_hh_reg <= mag_re[AccBits-1:HalfBits] * mag_re[AccBits-1:HalfBits];
                    re_hl_reg <= mag_re[AccBits-1:HalfBits] * mag_re[HalfBits-1:0];
                    re_ll_reg <= mag_re[HalfBits-1:0] * mag_re[HalfBits-1:0];
                    im_hh_reg <= mag_im[AccBits-1:HalfBits] * mag_im[AccBits-1:HalfBits];
                    im_hl_reg <= mag_im[AccBits-1:HalfBits] * mag_im[HalfBits-1:0];
                    im_ll_reg <= mag_im[HalfBits-1:0] * mag_im[HalfBits-1:0];
                    t_hh_reg  <= thr_ext[AccBits-1:HalfBits] * thr_ext[AccBits-1:HalfBits];
                    t_hl_reg  <= thr_ext[AccBits-1:HalfBits] * thr_ext[HalfBits-1:0];
                    t_ll_reg  <= thr_ext[HalfBits-1:0] * thr_ext[HalfBits-1:0];
                    st_reg    <= ST_SQ2;
                end
                ST_SQ2: begin
                    sq_re_reg <= {re_hh_reg, re_ll_reg} + (SqBits'(re_hl_reg) << (HalfBits + 1));
                    sq_im_reg <= {im_hh_reg, im_ll_reg} + (SqBits'(im_hl_reg) << (HalfBits + 1));
                    sq_t_reg  <= {t_hh_reg, t_ll_reg} + (SqBits'(t_hl_reg) << (HalfBits + 1));
                    st_reg    <= ST_CMP;
                end
                ST_CMP: begin
                    if (!phase_reg && c_reg.eos) begin
                        // The old group waits until the new group's test decides which is last.
                        pend_valid_reg <= keep;
                        pend_key_reg   <= hold_key_reg;
                        pend_re_reg    <= hold_re_reg;
                        pend_im_reg    <= hold_im_reg;
                        st_reg         <= ST_ACC;
                    end else if (keep || pend_valid_reg) begin
                        keep_reg <= keep;
                        st_reg   <= ST_OUT;
                    end else begin
                        st_reg <= phase_reg ? ST_IDLE : ST_ACC;
                    end
                end
                ST_OUT: begin
                    if (out_load) begin
                        if (pend_valid_reg) begin
                            out_reg.out_key      <= pend_key_reg;
                            out_reg.sum_re       <= pend_re_reg;
                            out_reg.sum_im       <= pend_im_reg;
                            out_reg.last_in_step <= !keep_reg;
                            pend_valid_reg       <= 1'b0;
                            if (!keep_reg) st_reg <= ST_IDLE;
                        end else begin
                            out_reg.out_key      <= hold_key_reg;
                            out_reg.sum_re       <= hold_re_reg;
                            out_reg.sum_im       <= hold_im_reg;
                            out_reg.last_in_step <= 1'b1;
                            st_reg <= phase_reg ? ST_IDLE : ST_ACC;
                        end
                    end
                end
                default: st_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

@@ src/sparse_tensor_vector_contract.sv @@
// Top level of the sparse tensor by dense vector contraction block.
// A load transaction is taken once the command queue is empty; in the back part an entry passes
// the multiply and accumulate states, and the square and compare states for each group that it
// closes, old, own or both. The back part takes a new entry only when idle, once it is through
// with the last one.
// A two-deep command queue parts the front from the back part.
// Synchronous active-low reset clears the accumulator, open group, queue and threshold.
module sparse_tensor_vector_contract import stvc_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    input  in_item_t     s_data,
    output logic         m_valid,
    input  logic         m_ready,
    output out_item_t    m_data,
    input  logic         cfg_wr_en,
    input  logic [ThrBits-1:0] cfg_wr_data
);

    logic [ThrBits-1:0] thr_reg;
    logic  cmd_valid, cmd_ready, ld_en;
    cmd_t  cmd_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) thr_reg <= '0;
        else if (cfg_wr_en) thr_reg <= cfg_wr_data;
    end

    assign ld_en = s_valid && s_ready && (s_data.mode == MODE_LOAD);

    stvc_front u_front (
        .aclk, .aresetn, .s_valid, .s_ready, .s_data,
        .cmd_valid, .cmd_ready, .cmd_data
    );

    stvc_back u_back (
        .aclk, .aresetn, .ld_en,
        .ld_addr(s_data.vec_addr), .ld_re(s_data.vec_re), .ld_im(s_data.vec_im),
        .thr(thr_reg), .cmd_valid, .cmd_ready, .cmd_data,
        .m_valid, .m_ready, .m_data
    );

endmodule

@@ src/stvc_checker.sv @@
// Port-level checker for the contraction block, bound to its top level.
module stvc_checker import stvc_pkg::*; (
    input logic      aclk,
    input logic      aresetn,
    input logic      s_ready,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_data
);

    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_no_instant: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(aresetn))
        else $error("result appeared out of reset");

    a_ready_reset: assert property (@(posedge aclk)
        !aresetn |=> s_ready)
        else $error("input not ready after reset");

endmodule

bind sparse_tensor_vector_contract stvc_checker u_checker (
    .aclk, .aresetn, .s_ready, .m_valid, .m_ready, .m_data
);
